FILE: src/assert_macros.svh
// Assertion helpers for the line follower block.
// Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lfs_pkg.sv
`default_nettype none

package lfs_pkg;

    // Row geometry
    localparam int ROW_WIDTH     = 320;
    localparam int CENTER_PIXELS = 40;
    localparam int SIDE_PIXELS   = ROW_WIDTH / 2 - 40;
    localparam int LEFT_START    = SIDE_PIXELS + 80;
    localparam int CENTER_START  = ROW_WIDTH / 2 - CENTER_PIXELS / 2;

    // Widths
    localparam int COL_W    = 9;
    localparam int SUM_W    = 13;
    localparam int CSUM_W   = 14;
    localparam int DRV_W    = 9;
    localparam int GAIN_W   = 16;
    localparam int MIX_W    = SUM_W + 2;

    localparam logic [COL_W-1:0]  COL_MAX  = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [CSUM_W-1:0] CSUM_MAX = '1;

    // Queues
    localparam int ROWQ_DEPTH = 2;
    localparam int ROWQ_AW    = 1;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHT_LEVEL   = 3'd0,
        CFG_BASE_SPEED     = 3'd1,
        CFG_GAIN_Q16       = 3'd2,
        CFG_JUNCTION_LIMIT = 3'd3,
        CFG_REVERSE_FAST   = 3'd4,
        CFG_REVERSE_SLOW   = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_FOLLOW   = 2'd0,
        ACT_RECOVER  = 2'd1,
        ACT_JUNCTION = 2'd2
    } action_t;

    typedef struct packed {
        logic [7:0]        bright_level;
        logic [7:0]        base_speed;
        logic [GAIN_W-1:0] gain_q16;
        logic [SUM_W-1:0]  junction_limit;
        logic [7:0]        reverse_fast;
        logic [7:0]        reverse_slow;
    } cfg_t;

    // One finished row as handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0]  right_sum;
        logic [SUM_W-1:0]  left_sum;
        logic [CSUM_W-1:0] center_sum;
    } row_sum_t;

    // One result word
    typedef struct packed {
        logic signed [DRV_W-1:0] left_drive;
        logic signed [DRV_W-1:0] right_drive;
        action_t                 action;
        logic [SUM_W-1:0]        right_sum;
        logic [SUM_W-1:0]        left_sum;
        logic                    center_lit;
    } steer_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic signed [DRV_W-1:0] clamp_drive(
        input logic signed [MIX_W-1:0] v
    );
        logic signed [MIX_W-1:0] pos_lim;
        logic signed [MIX_W-1:0] neg_lim;
        logic signed [DRV_W-1:0] r;
        pos_lim = MIX_W'(255);
        neg_lim = -pos_lim;
        if (v > pos_lim)
        begin
            r = pos_lim[DRV_W-1:0];
        end
        else if (v < neg_lim)
        begin
            r = neg_lim[DRV_W-1:0];
        end
        else
        begin
            r = v[DRV_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/lfs_front.sv
`default_nettype none

// Column counter and band accumulators; hands one row_sum_t per row end.
module lfs_front import lfs_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] pixel_value,
    input  wire logic       row_end,
    input  wire logic [7:0] bright_level,
    output logic            row_push,
    output row_sum_t        row_sum
);

    logic [COL_W-1:0]  col_reg,    col_next;
    logic [SUM_W-1:0]  right_reg,  right_next;
    logic [SUM_W-1:0]  left_reg,   left_next;
    logic [CSUM_W-1:0] center_reg, center_next;

    logic [COL_W:0]    col_x;
    logic              lit;
    logic              in_row, in_right, in_left, in_center;
    logic [COL_W-1:0]  right_w, left_w;
    logic [SUM_W:0]    right_add, left_add;
    logic [CSUM_W:0]   center_add;
    logic [SUM_W-1:0]  right_new, left_new;
    logic [CSUM_W-1:0] center_new;

    always_comb
    begin
        col_x     = {1'b0, col_reg};
        lit       = pixel_value > bright_level;
        in_row    = col_x < (COL_W+1)'(ROW_WIDTH);
        in_right  = lit && (col_x >= (COL_W+1)'(1)) && (col_x <= (COL_W+1)'(SIDE_PIXELS));
        in_left   = lit && in_row && (col_x >= (COL_W+1)'(LEFT_START));
        in_center = (col_x >= (COL_W+1)'(CENTER_START))
                 && (col_x < (COL_W+1)'(CENTER_START + CENTER_PIXELS));

        right_w = COL_W'(SIDE_PIXELS) - col_reg;
        left_w  = col_reg - COL_W'(LEFT_START);

        right_add  = (SUM_W+1)'(right_reg) + (SUM_W+1)'(right_w);
        left_add   = (SUM_W+1)'(left_reg) + (SUM_W+1)'(left_w);
        center_add = (CSUM_W+1)'(center_reg) + (CSUM_W+1)'(pixel_value);

        right_new  = right_reg;
        left_new   = left_reg;
        center_new = center_reg;
        if (in_right)
        begin
            right_new = right_add[SUM_W] ? SUM_MAX : right_add[SUM_W-1:0];
        end
        if (in_left)
        begin
            left_new = left_add[SUM_W] ? SUM_MAX : left_add[SUM_W-1:0];
        end
        if (in_center)
        begin
            center_new = center_add[CSUM_W] ? CSUM_MAX : center_add[CSUM_W-1:0];
        end

        row_push = accept && row_end;
        row_sum  = '{right_sum: right_new, left_sum: left_new, center_sum: center_new};

        col_next    = col_reg;
        right_next  = right_reg;
        left_next   = left_reg;
        center_next = center_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next    = '0;
                right_next  = '0;
                left_next   = '0;
                center_next = '0;
            end
            else
            begin
                col_next    = (col_reg == COL_MAX) ? col_reg : col_reg + COL_W'(1);
                right_next  = right_new;
                left_next   = left_new;
                center_next = center_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            right_reg  <= '0;
            left_reg   <= '0;
            center_reg <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            right_reg  <= right_next;
            left_reg   <= left_next;
            center_reg <= center_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/lfs_row_queue.sv
`default_nettype none

// Short queue of finished rows between front and back.
module lfs_row_queue import lfs_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  row_sum_t      din,
    input  wire logic     pop,
    output row_sum_t      dout,
    output q_status_t     status
);

    row_sum_t             entry_reg [ROWQ_DEPTH];
    logic [ROWQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ROWQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ROWQ_AW:0]     count_reg,  count_next;
    logic                 do_push, do_pop;

    always_comb
    begin
        status.empty = (count_reg == '0);
        status.full  = (count_reg == (ROWQ_AW+1)'(ROWQ_DEPTH));
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        dout         = entry_reg[rd_ptr_reg];

        wr_ptr_next = do_push ? wr_ptr_reg + ROWQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + ROWQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (ROWQ_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (ROWQ_AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/lfs_back.sv
`default_nettype none

// Decision pipeline: classify, multiply, mix/clamp, then result queue.
module lfs_back import lfs_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  cfg_t        cfg,
    input  row_sum_t    rq_word,
    input  q_status_t   rq_status,
    output logic        rq_pop,
    input  wire logic   out_pop,
    output steer_word_t out_word,
    output logic        out_empty,
    output logic        halted
);

    // stage 1: classified row
    logic              s1_valid_reg, s1_valid_next;
    action_t           s1_action_reg;
    logic [SUM_W-1:0]  s1_mag_reg;
    logic              s1_neg_reg;
    logic [SUM_W-1:0]  s1_right_reg, s1_left_reg;
    logic              s1_lit_reg;

    // stage 2: scaled error
    logic              s2_valid_reg, s2_valid_next;
    action_t           s2_action_reg;
    logic [SUM_W-1:0]  s2_f_reg;
    logic              s2_neg_reg;
    logic [SUM_W-1:0]  s2_right_reg, s2_left_reg;
    logic              s2_lit_reg;

    logic              halted_reg, halted_next;
    logic signed [DRV_W-1:0] last_left_reg, last_left_next;
    logic signed [DRV_W-1:0] last_right_reg, last_right_next;

    // result queue
    steer_word_t        oq_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] oq_wr_reg, oq_wr_next;
    logic [OUTQ_AW-1:0] oq_rd_reg, oq_rd_next;
    logic [OUTQ_AW:0]   oq_count_reg, oq_count_next;
    logic               oq_full, oq_write, oq_read;

    logic               adv;
    logic               c_lit, c_recover, c_junction, c_neg;
    logic [CSUM_W-1:0]  lit_limit;
    action_t            c_action;
    logic [SUM_W-1:0]   c_mag;
    logic [SUM_W+GAIN_W-1:0] prod;

    logic signed [MIX_W-1:0] base_s, f_s, right_mix, left_mix;
    logic signed [DRV_W-1:0] rev_fast_n, rev_slow_n;
    steer_word_t             new_word;

    always_comb
    begin
        oq_full   = (oq_count_reg == (OUTQ_AW+1)'(OUTQ_DEPTH));
        out_empty = (oq_count_reg == '0);
        out_word  = oq_reg[oq_rd_reg];
        adv       = !oq_full;
        rq_pop    = adv && !rq_status.empty;
        halted    = halted_reg;

        // classify
        lit_limit  = CSUM_W'(cfg.bright_level) * CSUM_W'(CENTER_PIXELS);
        c_lit      = rq_word.center_sum >= lit_limit;
        c_recover  = !c_lit && (rq_word.right_sum == '0) && (rq_word.left_sum == '0);
        c_junction = (rq_word.right_sum > cfg.junction_limit)
                  && (rq_word.left_sum > cfg.junction_limit);
        c_neg      = rq_word.left_sum > rq_word.right_sum;
        c_mag      = c_neg ? rq_word.left_sum - rq_word.right_sum
                           : rq_word.right_sum - rq_word.left_sum;
        if (c_recover)
        begin
            c_action = ACT_RECOVER;
        end
        else if (c_junction)
        begin
            c_action = ACT_JUNCTION;
        end
        else
        begin
            c_action = ACT_FOLLOW;
        end

        s1_valid_next = adv ? (rq_pop && !halted_reg) : s1_valid_reg;
        halted_next   = halted_reg || (rq_pop && !halted_reg && (c_action == ACT_JUNCTION));

        // scale
        prod          = (SUM_W+GAIN_W)'(s1_mag_reg) * (SUM_W+GAIN_W)'(cfg.gain_q16);
        s2_valid_next = adv ? s1_valid_reg : s2_valid_reg;

        // mix and clamp
        base_s     = $signed(MIX_W'(cfg.base_speed));
        f_s        = $signed(MIX_W'(s2_f_reg));
        right_mix  = s2_neg_reg ? base_s - f_s : base_s + f_s;
        left_mix   = s2_neg_reg ? base_s + f_s : base_s - f_s;
        rev_fast_n = -$signed({1'b0, cfg.reverse_fast});
        rev_slow_n = -$signed({1'b0, cfg.reverse_slow});

        new_word.action     = s2_action_reg;
        new_word.right_sum  = s2_right_reg;
        new_word.left_sum   = s2_left_reg;
        new_word.center_lit = s2_lit_reg;
        case (s2_action_reg)
            ACT_RECOVER:
            begin
                if (last_left_reg < last_right_reg)
                begin
                    new_word.left_drive  = rev_fast_n;
                    new_word.right_drive = rev_slow_n;
                end
                else
                begin
                    new_word.left_drive  = rev_slow_n;
                    new_word.right_drive = rev_fast_n;
                end
            end
            ACT_FOLLOW:
            begin
                new_word.left_drive  = clamp_drive(left_mix);
                new_word.right_drive = clamp_drive(right_mix);
            end
            default:
            begin
                new_word.left_drive  = '0;
                new_word.right_drive = '0;
            end
        endcase

        oq_write = adv && s2_valid_reg;
        oq_read  = out_pop && !out_empty;

        last_left_next  = last_left_reg;
        last_right_next = last_right_reg;
        if (oq_write && (s2_action_reg == ACT_FOLLOW))
        begin
            last_left_next  = new_word.left_drive;
            last_right_next = new_word.right_drive;
        end

        oq_wr_next    = oq_write ? oq_wr_reg + OUTQ_AW'(1) : oq_wr_reg;
        oq_rd_next    = oq_read  ? oq_rd_reg + OUTQ_AW'(1) : oq_rd_reg;
        oq_count_next = oq_count_reg;
        if (oq_write && !oq_read)
        begin
            oq_count_next = oq_count_reg + (OUTQ_AW+1)'(1);
        end
        else if (oq_read && !oq_write)
        begin
            oq_count_next = oq_count_reg - (OUTQ_AW+1)'(1);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_action_reg <= c_action;
            s1_mag_reg    <= c_mag;
            s1_neg_reg    <= c_neg;
            s1_right_reg  <= rq_word.right_sum;
            s1_left_reg   <= rq_word.left_sum;
            s1_lit_reg    <= c_lit;

            s2_action_reg <= s1_action_reg;
            s2_f_reg      <= prod[SUM_W+GAIN_W-1:GAIN_W];
            s2_neg_reg    <= s1_neg_reg;
            s2_right_reg  <= s1_right_reg;
            s2_left_reg   <= s1_left_reg;
            s2_lit_reg    <= s1_lit_reg;
        end
        if (oq_write)
        begin
            oq_reg[oq_wr_reg] <= new_word;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            halted_reg     <= 1'b0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            oq_wr_reg      <= '0;
            oq_rd_reg      <= '0;
            oq_count_reg   <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            halted_reg     <= halted_next;
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
            oq_wr_reg      <= oq_wr_next;
            oq_rd_reg      <= oq_rd_next;
            oq_count_reg   <= oq_count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/camera_line_follow_steering.sv
// Channel   Handshake               Payload
// -------   ---------------------   -----------------------------------------------
// pixel in  push / full             pixel_value, row_end
// result    empty / pop             left_drive, right_drive, action_code,
//                                   right_sum_out, left_sum_out, center_lit
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel per clock is taken whenever the row queue has room; full only
// rises when the consumer stalls long enough to back up the result queue.
// A row result reaches the result ports through the row queue, classify,
// multiply, and mix/clamp into the result queue.
// rst_n clears counters, accumulators, queues and the halt flag, and loads
// the register defaults. After a junction word all further pixels are
// taken and discarded until reset.
`default_nettype none

`include "assert_macros.svh"

module camera_line_follow_steering import lfs_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // pixel stream
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [7:0]             pixel_value,
    input  wire logic                   row_end,

    // result stream
    output logic                        empty,
    input  wire logic                   pop,
    output logic signed [DRV_W-1:0]     left_drive,
    output logic signed [DRV_W-1:0]     right_drive,
    output logic [1:0]                  action_code,
    output logic [SUM_W-1:0]            right_sum_out,
    output logic [SUM_W-1:0]            left_sum_out,
    output logic                        center_lit,

    // register writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t        cfg_reg, cfg_next;
    logic        in_accept;
    logic        row_push;
    row_sum_t    row_sum;
    row_sum_t    rq_word;
    q_status_t   rq_status;
    logic        rq_pop;
    logic        out_accept;
    steer_word_t out_word;
    logic        back_halted;

    // Writes never stall; unknown indexes fall through.
    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_next  = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BRIGHT_LEVEL:   cfg_next.bright_level   = cfg_data[7:0];
                CFG_BASE_SPEED:     cfg_next.base_speed     = cfg_data[7:0];
                CFG_GAIN_Q16:       cfg_next.gain_q16       = cfg_data[GAIN_W-1:0];
                CFG_JUNCTION_LIMIT: cfg_next.junction_limit = cfg_data[SUM_W-1:0];
                CFG_REVERSE_FAST:   cfg_next.reverse_fast   = cfg_data[7:0];
                CFG_REVERSE_SLOW:   cfg_next.reverse_slow   = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bright_level   <= 8'd120;
            cfg_reg.base_speed     <= 8'd80;
            cfg_reg.gain_q16       <= GAIN_W'(721);
            cfg_reg.junction_limit <= SUM_W'(1500);
            cfg_reg.reverse_fast   <= 8'd60;
            cfg_reg.reverse_slow   <= 8'd30;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pixel side backs off only when the row queue is full.
    assign full       = rq_status.full;
    assign in_accept  = push && !full;
    assign out_accept = pop && !empty;

    lfs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .pixel_value  (pixel_value),
        .row_end      (row_end),
        .bright_level (cfg_reg.bright_level),
        .row_push     (row_push),
        .row_sum      (row_sum)
    );

    lfs_row_queue u_row_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (row_push),
        .din    (row_sum),
        .pop    (rq_pop),
        .dout   (rq_word),
        .status (rq_status)
    );

    lfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rq_word   (rq_word),
        .rq_status (rq_status),
        .rq_pop    (rq_pop),
        .out_pop   (out_accept),
        .out_word  (out_word),
        .out_empty (empty),
        .halted    (back_halted)
    );

    assign left_drive    = out_word.left_drive;
    assign right_drive   = out_word.right_drive;
    assign action_code   = out_word.action;
    assign right_sum_out = out_word.right_sum;
    assign left_sum_out  = out_word.left_sum;
    assign center_lit    = out_word.center_lit;

    // A taken row-end pixel always leaves a row in the queue.
    `LFS_ASSERT_NXT(a_row_lands, in_accept && row_end, !rq_status.empty, "row end lost")
    // Junction halt holds until reset.
    `LFS_ASSERT_NXT(a_halt_sticky, back_halted, back_halted, "halt flag dropped")
    // A junction word carries stopped motors.
    `LFS_ASSERT_IMP(a_junction_stop, !empty && action_code == ACT_JUNCTION, left_drive == '0 && right_drive == '0, "junction drives not zero")

endmodule

`default_nettype wire

FILE: tb/lfs_steer_checker.sv
`timescale 1ns / 100ps

module lfs_steer_checker import lfs_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic                    full,
    input  logic [7:0]              pixel_value,
    input  logic                    row_end,
    input  logic                    empty,
    input  logic                    pop,
    input  logic signed [DRV_W-1:0] left_drive,
    input  logic signed [DRV_W-1:0] right_drive,
    input  logic [1:0]              action_code,
    input  logic [SUM_W-1:0]        right_sum_out,
    input  logic [SUM_W-1:0]        left_sum_out,
    input  logic                    center_lit,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      fail_count,
    output int                      pending
);

    localparam int NOTE_CAP      = 40;
    localparam int DRIVE_TOP     = 255;
    localparam int DEF_BRIGHT    = 120;
    localparam int DEF_BASE      = 80;
    localparam int DEF_GAIN      = 721;
    localparam int DEF_JUNCTION  = 1500;
    localparam int DEF_REV_FAST  = 60;
    localparam int DEF_REV_SLOW  = 30;

    // register copies
    int thr_bright;
    int spd_base;
    int gain;
    int junc_limit;
    int rev_fast;
    int rev_slow;

    // row state
    int col_pos;
    int right_band;
    int left_band;
    int center_raw;
    int prev_left;
    int prev_right;
    bit halted_seen;

    steer_word_t due_words[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int sat_add(input int a, input int b, input int top);
        return (a + b > top) ? top : a + b;
    endfunction

    function automatic int limit_drive(input int v);
        if (v > DRIVE_TOP)
            return DRIVE_TOP;
        if (v < -DRIVE_TOP)
            return -DRIVE_TOP;
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= NOTE_CAP)
            $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_BRIGHT_LEVEL:   thr_bright = int'(data[7:0]);
            CFG_BASE_SPEED:     spd_base   = int'(data[7:0]);
            CFG_GAIN_Q16:       gain       = int'(data[GAIN_W-1:0]);
            CFG_JUNCTION_LIMIT: junc_limit = int'(data[SUM_W-1:0]);
            CFG_REVERSE_FAST:   rev_fast   = int'(data[7:0]);
            CFG_REVERSE_SLOW:   rev_slow   = int'(data[7:0]);
            default: ;
        endcase
    endtask

    // One pixel in (skip once halted); a row end queues its steering word.
    task automatic take_pixel(input logic [7:0] pv, input logic last);
        int col;
        bit lit_px;
        bit lit_mid;
        int diff;
        int nudge;
        int l_drv;
        int r_drv;
        longint scaled;
        steer_word_t w;
        if (halted_seen)
            return;
        col = col_pos;
        lit_px = int'(pv) > thr_bright;
        if (col < ROW_WIDTH)
        begin
            if (lit_px && col >= 1 && col <= SIDE_PIXELS)
                right_band = sat_add(right_band, SIDE_PIXELS - col, int'(SUM_MAX));
            if (lit_px && col >= LEFT_START && col < LEFT_START + SIDE_PIXELS)
                left_band = sat_add(left_band, col - LEFT_START, int'(SUM_MAX));
            if (col >= CENTER_START && col < CENTER_START + CENTER_PIXELS)
                center_raw = sat_add(center_raw, int'(pv), int'(CSUM_MAX));
        end
        if (!last)
        begin
            if (col_pos < int'(COL_MAX))
                col_pos++;
            return;
        end
        lit_mid = center_raw >= thr_bright * CENTER_PIXELS;
        l_drv = 0;
        r_drv = 0;
        if (!lit_mid && right_band == 0 && left_band == 0)
        begin
            w.action = ACT_RECOVER;
            if (prev_left < prev_right)
            begin
                l_drv = -rev_fast;
                r_drv = -rev_slow;
            end
            else
            begin
                l_drv = -rev_slow;
                r_drv = -rev_fast;
            end
        end
        else if (right_band > junc_limit && left_band > junc_limit)
        begin
            w.action = ACT_JUNCTION;
            halted_seen = 1'b1;
        end
        else
        begin
            diff = right_band - left_band;
            scaled = longint'(diff < 0 ? -diff : diff) * longint'(gain);
            nudge = int'(scaled >>> 16);
            if (diff < 0)
                nudge = -nudge;
            r_drv = limit_drive(spd_base + nudge);
            l_drv = limit_drive(spd_base - nudge);
            prev_left  = l_drv;
            prev_right = r_drv;
            w.action = ACT_FOLLOW;
        end
        w.left_drive  = DRV_W'(l_drv);
        w.right_drive = DRV_W'(r_drv);
        w.right_sum   = SUM_W'(right_band);
        w.left_sum    = SUM_W'(left_band);
        w.center_lit  = lit_mid;
        due_words.push_back(w);
        col_pos    = 0;
        right_band = 0;
        left_band  = 0;
        center_raw = 0;
    endtask

    task automatic check_word();
        steer_word_t w;
        if (due_words.size() == 0)
        begin
            flag_mismatch("word with none due, action", int'(action_code), -1);
            return;
        end
        w = due_words.pop_front();
        if (left_drive !== w.left_drive)
            flag_mismatch("left_drive", left_drive, w.left_drive);
        if (right_drive !== w.right_drive)
            flag_mismatch("right_drive", right_drive, w.right_drive);
        if (action_code !== w.action)
            flag_mismatch("action_code", int'(action_code), int'(w.action));
        if (right_sum_out !== w.right_sum)
            flag_mismatch("right_sum_out", int'(right_sum_out), int'(w.right_sum));
        if (left_sum_out !== w.left_sum)
            flag_mismatch("left_sum_out", int'(left_sum_out), int'(w.left_sum));
        if (center_lit !== w.center_lit)
            flag_mismatch("center_lit", int'(center_lit), int'(w.center_lit));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_bright  = DEF_BRIGHT;
            spd_base    = DEF_BASE;
            gain        = DEF_GAIN;
            junc_limit  = DEF_JUNCTION;
            rev_fast    = DEF_REV_FAST;
            rev_slow    = DEF_REV_SLOW;
            col_pos     = 0;
            right_band  = 0;
            left_band   = 0;
            center_raw  = 0;
            prev_left   = 0;
            prev_right  = 0;
            halted_seen = 1'b0;
            due_words.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (pop && !empty)
                check_word();
            if (push && !full)
                take_pixel(pixel_value, row_end);
            pending = due_words.size();
        end
    end

endmodule

FILE: tb/tb_camera_line_follow_steering.sv
`timescale 1ns / 100ps

module tb_camera_line_follow_steering import lfs_pkg::*;;

    // Pacing and limits. The long hold is far beyond what the block can
    // buffer (two rows in front, four words behind), so full must rise.
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;

    // Largest weighted band sum a single row can reach; a junction limit at
    // or above it can never be crossed.
    localparam int BAND_SUM_TOP = SIDE_PIXELS * (SIDE_PIXELS - 1) / 2;

    // Register indexes past the last register; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int { ROW_DARK, ROW_BRIGHT, ROW_NOISE, ROW_LINE } row_look_t;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic [7:0]              pixel_value;
    logic                    row_end;
    logic                    empty;
    logic                    pop;
    logic signed [DRV_W-1:0] left_drive;
    logic signed [DRV_W-1:0] right_drive;
    logic [1:0]              action_code;
    logic [SUM_W-1:0]        right_sum_out;
    logic [SUM_W-1:0]        left_sum_out;
    logic                    center_lit;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int idle_cycles;

    // Stimulus-side view of the two registers that shape the pixel content.
    int cur_bright;
    int cur_junction;

    // Random stalls on both sides; cleared for the last part of the run.
    bit stalls_on;

    // Sender asks for a long receiver hold by bumping the ticket count.
    int hold_tickets;
    int holds_served;

    camera_line_follow_steering uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .pixel_value   (pixel_value),
        .row_end       (row_end),
        .empty         (empty),
        .pop           (pop),
        .left_drive    (left_drive),
        .right_drive   (right_drive),
        .action_code   (action_code),
        .right_sum_out (right_sum_out),
        .left_sum_out  (left_sum_out),
        .center_lit    (center_lit),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lfs_steer_checker steer_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .pixel_value   (pixel_value),
        .row_end       (row_end),
        .empty         (empty),
        .pop           (pop),
        .left_drive    (left_drive),
        .right_drive   (right_drive),
        .action_code   (action_code),
        .right_sum_out (right_sum_out),
        .left_sum_out  (left_sum_out),
        .center_lit    (center_lit),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Pixel side. Inputs move on the falling edge; the handshake is looked
    // at right after the rising edge, before the block's own updates land.
    // ------------------------------------------------------------------

    // Offer one pixel and hold it until the block takes it.
    task automatic offer_pixel(input logic [7:0] pv, input logic last);
        @(negedge clk);
        push        <= 1'b1;
        pixel_value <= pv;
        row_end     <= last;
        do
            @(posedge clk);
        while (full);
    endtask

    // Occasional burst of dead cycles on the pixel side.
    task automatic maybe_pause();
        if (stalls_on && $urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 18))
            begin
                @(negedge clk);
                push <= 1'b0;
            end
        end
    endtask

    function automatic logic [7:0] dark_pixel();
        return 8'($urandom_range(0, cur_bright));
    endfunction

    function automatic logic [7:0] lit_pixel();
        return (cur_bright >= 255) ? 8'd255 : 8'($urandom_range(cur_bright + 1, 255));
    endfunction

    // Row of fixed content: columns lo..hi carry on_val, the rest off_val.
    task automatic send_span_row(input int len, input int lo, input int hi,
                                 input logic [7:0] on_val, input logic [7:0] off_val);
        for (int c = 0; c < len; c++)
        begin
            maybe_pause();
            offer_pixel((c >= lo && c <= hi) ? on_val : off_val, c == len - 1);
        end
    endtask

    // Random row. Half the lengths are the nominal width, with short, tiny and
    // overlong rows mixed in (the longest of them run the column count into
    // its hold). While the junction limit is reachable, one band is kept dark so
    // the block never halts before the end of the run.
    task automatic send_random_row(input bit tiny);
        int len;
        int lo;
        int hi;
        int pick;
        bit guard;
        bit kill_left;
        bit kill_right;
        bit calm;
        row_look_t look;
        logic [7:0] pv;
        pick = $urandom_range(0, 19);
        if (tiny)
            len = $urandom_range(1, 4);
        else if (pick < 10)
            len = ROW_WIDTH;
        else if (pick < 15)
            len = $urandom_range(1, ROW_WIDTH - 1);
        else if (pick < 18)
            len = $urandom_range(ROW_WIDTH + 1, 2 * ROW_WIDTH);
        else
            len = $urandom_range(1, 6);
        look = row_look_t'($urandom_range(0, 3));
        lo = $urandom_range(0, ROW_WIDTH - 1);
        hi = lo + $urandom_range(0, 60);
        guard = cur_junction < BAND_SUM_TOP;
        kill_left  = guard && ($urandom_range(0, 1) == 1);
        kill_right = guard && !kill_left;
        calm = tiny || ($urandom_range(0, 2) == 0);
        for (int c = 0; c < len; c++)
        begin
            case (look)
                ROW_DARK:   pv = dark_pixel();
                ROW_BRIGHT: pv = lit_pixel();
                ROW_NOISE:  pv = 8'($urandom);
                default:    pv = (c >= lo && c <= hi) ? lit_pixel() : dark_pixel();
            endcase
            // zero is never above the threshold, so a zeroed band stays dark
            if (kill_right && c >= 1 && c <= SIDE_PIXELS)
                pv = 8'd0;
            if (kill_left && c >= LEFT_START && c < ROW_WIDTH)
                pv = 8'd0;
            if (!calm)
                maybe_pause();
            offer_pixel(pv, c == len - 1);
        end
    endtask

    // Stop offering, let every due word come out, then give the back end
    // a settling wait before anything else (register writes) happens.
    task automatic wait_drain();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Register writes. Bits above a register's width carry junk so every
    // data bit toggles; the block has to mask them off.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        int keep;
        logic [CFG_DATA_W-1:0] word;
        case (idx)
            CFG_GAIN_Q16:       keep = (1 << GAIN_W) - 1;
            CFG_JUNCTION_LIMIT: keep = (1 << SUM_W) - 1;
            default:            keep = 255;
        endcase
        word = CFG_DATA_W'((int'($urandom) & ~keep) | (value & keep));
        if (idx == CFG_BRIGHT_LEVEL)
            cur_bright = int'(word[7:0]);
        if (idx == CFG_JUNCTION_LIMIT)
            cur_junction = int'(word[SUM_W-1:0]);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input int bright, input int base, input int gain,
                               input int junction, input int fast, input int slow);
        write_reg(CFG_BRIGHT_LEVEL, bright);
        write_reg(CFG_BASE_SPEED, base);
        write_reg(CFG_GAIN_Q16, gain);
        write_reg(CFG_JUNCTION_LIMIT, junction);
        write_reg(CFG_REVERSE_FAST, fast);
        write_reg(CFG_REVERSE_SLOW, slow);
    endtask

    task automatic run_rows(input int count);
        repeat (count)
            send_random_row(1'b0);
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Result side: runs of pop high, random stall bursts, and on request
    // one long hold counted here so the pixel side backs up.
    // ------------------------------------------------------------------
    initial
    begin : result_drain
        int n;
        forever
        begin
            if (hold_tickets != holds_served)
            begin
                holds_served++;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    pop <= 1'b0;
                end
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 18);
                repeat (n)
                begin
                    @(negedge clk);
                    pop <= 1'b0;
                end
            end
            else
            begin
                n = $urandom_range(1, 40);
                repeat (n)
                begin
                    @(negedge clk);
                    pop <= 1'b1;
                end
            end
        end
    end

    // Watchdog: too long with no word moving on any channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n        = 1'b0;
        push         = 1'b0;
        pixel_value  = 8'd0;
        row_end      = 1'b0;
        pop          = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_BRIGHT_LEVEL;
        cfg_data     = '0;
        idle_cycles  = 0;
        cur_bright   = 120;
        cur_junction = 1500;
        stalls_on    = 1'b1;
        hold_tickets = 0;
        holds_served = 0;

        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows under reset defaults (threshold 120, junction 1500).
        // None of them lights both bands, so no junction yet.
        send_span_row(1, 0, 0, 8'd0, 8'd0);                  // one-pixel row: recovery
        send_span_row(ROW_WIDTH, 0, -1, 8'd0, 8'd0);         // all dark: recovery
        send_span_row(ROW_WIDTH, CENTER_START, CENTER_START + CENTER_PIXELS - 1,
                      8'd255, 8'd0);                          // center only: zero error
        send_span_row(ROW_WIDTH, 1, 1, 8'd255, 8'd0);        // heaviest right column
        send_span_row(ROW_WIDTH, 0, -1, 8'd0, 8'd0);         // recovery, left reverses faster
        send_span_row(ROW_WIDTH, ROW_WIDTH - 1, ROW_WIDTH - 1,
                      8'd255, 8'd0);                          // heaviest left column
        send_span_row(ROW_WIDTH, 0, -1, 8'd0, 8'd0);         // recovery, other way
        send_span_row(ROW_WIDTH, 0, 0, 8'd255, 8'd0);        // column 0 is in no band
        send_span_row(ROW_WIDTH, SIDE_PIXELS, SIDE_PIXELS,
                      8'd255, 8'd0);                          // zero-weight column
        send_span_row(ROW_WIDTH, 0, ROW_WIDTH - 1, 8'd120, 8'd120); // at threshold: center lit
        send_span_row(ROW_WIDTH, CENTER_START, CENTER_START + CENTER_PIXELS - 1,
                      8'd119, 8'd0);                          // center just short of lit
        send_span_row(2 * ROW_WIDTH, ROW_WIDTH, 2 * ROW_WIDTH - 1,
                      8'd255, 8'd0);                          // overlong, bright tail ignored
        send_span_row(100, 1, 99, 8'd255, 8'd0);             // short row, right band only
        send_span_row(2, 1, 1, 8'd255, 8'd0);                // two-pixel row
        wait_drain();

        // Random rows, defaults still loaded.
        run_rows(8);

        // Extremes: every nonzero pixel counts as lit, full gain, widest swing.
        load_config(0, 255, 65535, 8191, 255, 0);
        run_rows(8);

        // Opposite extremes: nothing can be lit on the sides, no gain.
        load_config(255, 0, 0, 8191, 0, 255);
        write_reg(CFG_SPARE_LO, int'($urandom));
        write_reg(CFG_SPARE_HI, int'($urandom));
        run_rows(8);

        // Random settings; about half the time a reachable junction limit,
        // which the row generator guards against.
        repeat (3)
        begin
            load_config($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 65535),
                        ($urandom_range(0, 1) == 1) ? $urandom_range(0, BAND_SUM_TOP) : 8191,
                        $urandom_range(0, 255), $urandom_range(0, 255));
            run_rows(8);
        end

        // Back pressure: receiver holds off while tiny rows keep coming,
        // filling both queues until full rises.
        hold_tickets++;
        repeat (150)
            send_random_row(1'b1);
        wait_drain();

        // Last part without any stalls.
        stalls_on = 1'b0;
        load_config($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 65535), 8191,
                    $urandom_range(0, 255), $urandom_range(0, 255));
        run_rows(8);

        // Junction: both bands over a zero limit halts the block. Pixels
        // right behind it, row ends included, must vanish.
        load_config(0, $urandom_range(0, 255), $urandom_range(0, 65535), 0,
                    $urandom_range(0, 255), $urandom_range(0, 255));
        send_span_row(ROW_WIDTH, 0, ROW_WIDTH - 1, 8'd255, 8'd0);
        repeat (40)
            offer_pixel(8'($urandom), $urandom_range(0, 3) == 0);
        wait_drain();

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/lfs_pkg.sv
src/lfs_front.sv
src/lfs_row_queue.sv
src/lfs_back.sv
src/camera_line_follow_steering.sv
tb/lfs_steer_checker.sv
tb/tb_camera_line_follow_steering.sv
